### rtl/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// shared constants and types for the prime factor sum core
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int VALUE_BITS_DEF = 31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_FINISH
  } pfs_state_t;

endpackage

### rtl/pfs_div.sv
// ----------------------------------------------------------------------------
// pfs_div
// restoring divider, one quotient bit per cycle, gives quotient and remainder
// ----------------------------------------------------------------------------
module pfs_div #(
  parameter int VALUE_BITS = pfs_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [VALUE_BITS-1:0] remainder
);
  import pfs_pkg::*;

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS-1:0] dsr;
  logic [CW-1:0]         cnt;
  logic [VALUE_BITS:0]   trial;

  // shift in the next dividend bit and try to subtract
  assign trial = {rem, quo[VALUE_BITS-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[VALUE_BITS]) begin
        rem <= trial[VALUE_BITS-1:0];
        quo <= {quo[VALUE_BITS-2:0], 1'b1};
      end else begin
        rem <= {rem[VALUE_BITS-2:0], quo[VALUE_BITS-1]};
        quo <= {quo[VALUE_BITS-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### rtl/prime_factor_sum_core.sv
// ----------------------------------------------------------------------------
// prime_factor_sum_core
// sums the prime factors of an integer, with multiplicity, by trial division
// ----------------------------------------------------------------------------
// One item is taken at a time. The value is factored by trial division with
// a single restoring divider that produces one quotient bit per cycle; the
// number of trial divisions is about sqrt(value) plus the number of prime
// factors, and a value below 2 skips the search. The input is accepted again
// as soon as the result sits in the output register, even while that result
// waits to be taken.
module prime_factor_sum_core #(
  parameter int VALUE_BITS = pfs_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  no_factor,
  output logic [VALUE_BITS-1:0] factor_sum
);
  import pfs_pkg::*;

  pfs_state_t state, state_next;

  logic [VALUE_BITS-1:0] rest, rest_next;
  logic [VALUE_BITS-1:0] d, d_next;
  logic [VALUE_BITS-1:0] total, total_next;
  logic                  divided, divided_next;
  logic                  out_valid_next;
  logic                  out_load;
  logic [VALUE_BITS-1:0] addend;
  logic [VALUE_BITS-1:0] sum;

  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [VALUE_BITS-1:0] div_rem;

  pfs_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rest),
    .divisor   (d),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign sum      = total + addend;
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    rest_next      = rest;
    d_next         = d;
    total_next     = total;
    divided_next   = divided;
    addend         = '0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          rest_next    = value;
          d_next       = VALUE_BITS'(2);
          total_next   = '0;
          divided_next = 1'b0;
          // zero and one skip the search
          state_next   = (value[VALUE_BITS-1:1] == '0) ? ST_FINISH : ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          if (d > div_quo) begin
            // divisor past the square root: leftover cofactor is prime
            if (divided && (rest[VALUE_BITS-1:1] != '0)) begin
              addend = rest;
            end
            total_next = sum;
            state_next = ST_FINISH;
          end else if (div_rem == '0) begin
            addend       = d;
            total_next   = sum;
            rest_next    = div_quo;
            divided_next = 1'b1;
            state_next   = ST_LAUNCH;
          end else begin
            d_next     = d + 1'b1;
            state_next = ST_LAUNCH;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      divided   <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      divided   <= divided_next;
    end
  end

  always_ff @(posedge clk) begin
    rest  <= rest_next;
    d     <= d_next;
    total <= total_next;
    if (out_load) begin
      no_factor  <= !divided;
      factor_sum <= divided ? total : '0;
    end
  end

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    div_done |-> $past(div_busy))
    else $error("divider done without a division in flight");

  a_divisor_floor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LAUNCH || state == ST_WAIT) |-> (d[VALUE_BITS-1:1] != '0))
    else $error("trial divisor below two");

  a_no_factor_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && no_factor |-> (factor_sum == '0))
    else $error("no-factor result with nonzero sum");

endmodule

### bench/pfs_checker.sv
// ----------------------------------------------------------------------------
// pfs_checker
// predicts and checks the results of the prime factor sum core
// ----------------------------------------------------------------------------
// Watches both channels of the core. Every accepted value is factored here
// by trial division, and the outcome is queued. Every accepted result is
// compared field by field with the oldest queued outcome. Mismatches and
// unexpected results are counted and handed to the top.
module pfs_checker #(
  parameter int VALUE_BITS = pfs_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  no_factor,
  input  logic [VALUE_BITS-1:0] factor_sum,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  no_factor;
    logic [VALUE_BITS-1:0] factor_sum;
  } factoring_t;

  factoring_t factorings_q[$];

  function automatic factoring_t factor_value(input logic [VALUE_BITS-1:0] v);
    longint unsigned rest;
    longint unsigned total;
    longint unsigned divisor;
    bit              divided;
    factoring_t      outcome;
    rest    = 64'(v);
    total   = 0;
    divisor = 2;
    divided = 1'b0;
    if (rest >= 2) begin
      while (divisor <= rest / divisor) begin
        if (rest % divisor == 0) begin
          total   += divisor;
          rest    /= divisor;
          divided  = 1'b1;
        end else begin
          divisor++;
        end
      end
      // whatever cofactor is left above one is the largest prime factor
      if (divided && rest > 1)
        total += rest;
    end
    outcome.no_factor  = !divided;
    outcome.factor_sum = divided ? total[VALUE_BITS-1:0] : '0;
    return outcome;
  endfunction

  always @(posedge clk) begin
    int         errs;
    factoring_t want;
    errs = 0;
    if (rst) begin
      factorings_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (factorings_q.size() == 0) begin
          $error("result with no item outstanding: no_factor %0d factor_sum %0d",
                 no_factor, factor_sum);
          errs++;
        end else begin
          want = factorings_q.pop_front();
          if (no_factor !== want.no_factor) begin
            $error("no_factor mismatch: expected %0d, actual %0d",
                   want.no_factor, no_factor);
            errs++;
          end
          if (factor_sum !== want.factor_sum) begin
            $error("factor_sum mismatch: expected %0d, actual %0d",
                   want.factor_sum, factor_sum);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall)
        factorings_q.push_back(factor_value(value));
      fail_count <= fail_count + errs;
      pending    <= factorings_q.size();
    end
  end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench for the prime factor sum core
// ----------------------------------------------------------------------------
// Feeds directed values (zero, one, small primes and composites, powers of
// two, wide bit patterns) and then random values, mostly small numbers
// shifted across the field so every bit toggles while run time stays low.
// Both sides idle at random; the checker predicts and compares each result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     VB            = pfs_pkg::VALUE_BITS_DEF;
  localparam int     RANDOM_ITEMS  = 600;
  localparam int     CALM_ITEMS    = 60;
  localparam longint CYCLE_LIMIT   = 20_000_000;
  localparam int     DRAIN_CYCLES  = 100;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  logic [VB-1:0] value;
  logic          out_valid;
  logic          out_stall;
  logic          no_factor;
  logic [VB-1:0] factor_sum;
  logic          calm;
  int            fail_count;
  int            pending;
  longint        cycles;

  prime_factor_sum_core #(.VALUE_BITS(VB)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .no_factor (no_factor),
    .factor_sum(factor_sum)
  );

  pfs_checker #(.VALUE_BITS(VB)) chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .no_factor (no_factor),
    .factor_sum(factor_sum),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hang guard
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // result side: random stall bursts, none once calm
  initial begin
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (calm || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  // hold the item until it is taken; returns right after the accepting edge
  task automatic offer_value(input logic [VB-1:0] v);
    in_valid <= 1'b1;
    value    <= v;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [VB-1:0] random_value();
    int unsigned pick;
    logic [63:0] wide;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      wide = 64'($urandom_range(0, 3));
    else if (pick == 1)
      wide = 64'($urandom_range(0, 65535));
    else if (pick <= 3)
      wide = 64'($urandom_range(2, 2000));
    else
      // small odd part keeps the trial divisions few at any magnitude
      wide = 64'($urandom_range(0, 255)) << $urandom_range(0, VB - 8);
    return wide[VB-1:0];
  endfunction

  logic [VB-1:0] directed_values[$] = '{
    VB'(0), VB'(1), VB'(2), VB'(3), VB'(4), VB'(5), VB'(6), VB'(8), VB'(9),
    VB'(12), VB'(25), VB'(49), VB'(97),
    VB'(1) << (VB - 1),
    VB'(3) << (VB - 2),
    {1'b0, {(VB-1){1'b1}}} << 1,
    VB'({(VB/2){2'b10}}),
    VB'({(VB/2 + 1){2'b01}}),
    VB'(65521),
    VB'(1021 * 1019),
    VB'(2 * 1021 * 1021)
  };

  initial begin
    calm     = 1'b0;
    rst      = 1'b1;
    in_valid = 1'b0;
    value    = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_values[i]) begin
      offer_value(directed_values[i]);
      maybe_idle();
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        // let the core drain completely before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS)
        calm = 1'b1;
      offer_value(random_value());
      maybe_idle();
    end
    in_valid <= 1'b0;

    // the count seen right after the last accepting edge is still stale
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### prime_factor_sum_core.f
rtl/pfs_pkg.sv
rtl/pfs_div.sv
rtl/prime_factor_sum_core.sv
bench/pfs_checker.sv
bench/tb_top.sv
